[rtl/core/tiny_cpu_execute_unit_macros.svh]
// Assertion macros for the tiny CPU execute unit.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef TINY_CPU_EXECUTE_UNIT_MACROS_SVH
`define TINY_CPU_EXECUTE_UNIT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define TCPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define TCPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/tcpu_pkg.sv]
// Shared types and constants of the tiny CPU execute unit.
// No dependencies.
package tcpu_pkg;

    // item kinds on the input channel
    typedef enum logic {
        ITEM_EXEC    = 1'b0,
        ITEM_PRELOAD = 1'b1
    } t_item_kind;

    typedef enum logic [1:0] {
        PRINT_NONE = 2'd0,
        PRINT_HEX  = 2'd1,
        PRINT_CHAR = 2'd2
    } t_print_kind;

    // opcode top bits that select instruction length
    localparam logic [1:0] LEN2_TAG = 2'b01;
    localparam logic [1:0] LEN3_TAG = 2'b10;

    // locations at and above this address map to data memory
    localparam logic [7:0] MEM_BASE = 8'h10;

    localparam logic [7:0] OPC_NOP    = 8'h00;
    localparam logic [7:0] OPC_HALT   = 8'h3F;
    localparam logic [7:0] OPC_MOV    = 8'h81;
    localparam logic [7:0] OPC_ADD    = 8'h82;
    localparam logic [7:0] OPC_SUB    = 8'h83;
    localparam logic [7:0] OPC_PRHEX  = 8'h44;
    localparam logic [7:0] OPC_PRCHR  = 8'h45;
    localparam logic [7:0] OPC_NOT    = 8'h46;
    localparam logic [7:0] OPC_OR     = 8'h87;
    localparam logic [7:0] OPC_AND    = 8'h88;
    localparam logic [7:0] OPC_XOR    = 8'h89;
    localparam logic [7:0] OPC_SHR    = 8'h8A;
    localparam logic [7:0] OPC_SHL    = 8'h8B;
    localparam logic [7:0] OPC_JMP    = 8'h8C;
    localparam logic [7:0] OPC_SKIPNZ = 8'h4D;
    localparam logic [7:0] OPC_EQ     = 8'h8E;

    // decode/execute result handed from the ALU to the top level
    typedef struct packed {
        logic        reg_we;      // write R[a]
        logic        mov;         // location move, data in reg_wdata
        logic [7:0]  reg_wdata;
        logic        jump;
        logic [15:0] jump_pc;
        logic        set_halt;
        logic        set_skip;
        t_print_kind print_kind;
        logic [7:0]  print_value;
        logic        illegal;
    } t_exec_res;

endpackage

[rtl/core/tcpu_alu.sv]
// Instruction decode and execute datapath of the tiny CPU.
// Depends on tcpu_pkg.
module tcpu_alu
    import tcpu_pkg::*;
(
    input  logic [7:0] i_opcode,
    input  logic [7:0] i_ra,
    input  logic [7:0] i_rb,
    input  logic [7:0] i_loc_a,
    output t_exec_res  o_res
);

    always_comb begin
        o_res             = '0;
        o_res.print_kind  = PRINT_NONE;
        // Ra*255 + Rb as (Ra<<8) - Ra + Rb
        o_res.jump_pc     = {i_ra, 8'h00} - {8'h00, i_ra} + {8'h00, i_rb};
        case (i_opcode)
            OPC_NOP: begin
            end
            OPC_HALT: begin
                o_res.set_halt = 1'b1;
            end
            OPC_MOV: begin
                o_res.mov       = 1'b1;
                o_res.reg_wdata = i_loc_a;
            end
            OPC_ADD: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = i_ra + i_rb;
            end
            OPC_SUB: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = i_ra - i_rb;
            end
            OPC_PRHEX: begin
                o_res.print_kind  = PRINT_HEX;
                o_res.print_value = i_loc_a;
            end
            OPC_PRCHR: begin
                o_res.print_kind  = PRINT_CHAR;
                o_res.print_value = i_loc_a;
            end
            OPC_NOT: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = {7'd0, (i_ra == 8'h00)};
            end
            OPC_OR: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = {7'd0, ((i_ra != 8'h00) || (i_rb != 8'h00))};
            end
            OPC_AND: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = {7'd0, ((i_ra != 8'h00) && (i_rb != 8'h00))};
            end
            OPC_XOR: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = i_ra ^ i_rb;
            end
            OPC_SHR: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = (i_rb >= 8'd8) ? 8'h00 : (i_ra >> i_rb[2:0]);
            end
            OPC_SHL: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = (i_rb >= 8'd8) ? 8'h00 : (i_ra << i_rb[2:0]);
            end
            OPC_JMP: begin
                o_res.jump = 1'b1;
            end
            OPC_SKIPNZ: begin
                o_res.set_skip = (i_ra != 8'h00);
            end
            OPC_EQ: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = {7'd0, (i_ra == i_rb)};
            end
            default: begin
                o_res.illegal = 1'b1;
            end
        endcase
    end

endmodule

[rtl/core/tiny_cpu_execute_unit.sv]
// Tiny CPU execute unit: top level. Depends on tcpu_pkg, tcpu_alu and the macros header.
// Items pass the operand stage, then the output register. Throughput: one item per
//   cycle when not stalled; the register file and data memory each take one write per
//   cycle, and a write to a location read by the next item is forwarded.
// Reset (i_rst_n low, synchronous): pc, skip and halt clear, every register and memory
//   byte reads as zero through per-entry valid bits, pipeline empties.
`include "tiny_cpu_execute_unit_macros.svh"

module tiny_cpu_execute_unit
    import tcpu_pkg::*;
#(
    parameter int REG_COUNT = 8,
    parameter int MEM_DEPTH = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // opcode[7:0], operand_a[15:8], operand_b[23:16], preload_index[31:24],
    // preload_data[39:32]
    input  logic [39:0] i_s_axis_tdata,
    // op[0]
    input  logic [0:0]  i_s_axis_tuser,
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // next_pc[15:0], print_value[23:16], halted[24], illegal[25], zero[31:26]
    output logic [31:0] o_m_axis_tdata,
    // print_kind[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    localparam int RIDX_W = $clog2(REG_COUNT);
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam logic [7:0] MEM_DEPTH_B = 8'(MEM_DEPTH);

    // index mod REG_COUNT by restoring subtraction, five narrow steps
    function automatic logic [RIDX_W-1:0] f_ridx(input logic [7:0] v);
        logic [12:0] rem;
        rem = {5'd0, v};
        for (int k = 4; k >= 0; k--) begin
            if (rem >= 13'(REG_COUNT << k)) begin
                rem = rem - 13'(REG_COUNT << k);
            end
        end
        return rem[RIDX_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Storage: register file (2R1W) and data memory (1R1W), with valid bits
    // so that reset makes every entry read as zero at once.
    // ---------------------------------------------------------------
    logic [7:0]           r_reg_file [REG_COUNT];
    logic [REG_COUNT-1:0] r_reg_vld;
    logic [7:0]           r_data_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_vld;

    // write ports, driven by the execute stage
    logic              reg_we;
    logic [RIDX_W-1:0] reg_waddr;
    logic [7:0]        reg_wdata;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    // architectural state
    logic [15:0] r_pc;
    logic        r_skip;
    logic        r_halt;

    // ---------------------------------------------------------------
    // Input decode: operand masking by length and read addresses
    // ---------------------------------------------------------------
    logic [7:0]        in_opc;
    logic [7:0]        in_a;
    logic [7:0]        in_b;
    logic [1:0]        in_top;
    logic [7:0]        in_a_eff;
    logic [7:0]        in_b_eff;
    logic [RIDX_W-1:0] in_ia;
    logic [RIDX_W-1:0] in_ib;
    logic [7:0]        in_moff;
    logic              in_m_inr;
    logic [MEM_AW-1:0] in_maddr;
    logic              in_acc;
    logic              a_adv;

    assign in_opc   = i_s_axis_tdata[7:0];
    assign in_a     = i_s_axis_tdata[15:8];
    assign in_b     = i_s_axis_tdata[23:16];
    assign in_top   = in_opc[7:6];
    // two-byte ops see b as 0, one-byte ops see both as 0
    assign in_a_eff = ((in_top == LEN2_TAG) || (in_top == LEN3_TAG)) ? in_a : 8'h00;
    assign in_b_eff = (in_top == LEN3_TAG) ? in_b : 8'h00;
    assign in_ia    = f_ridx(in_a_eff);
    assign in_ib    = f_ridx(in_b_eff);
    assign in_moff  = in_a_eff - MEM_BASE;
    assign in_m_inr = (in_a_eff >= MEM_BASE) && (in_moff < MEM_DEPTH_B);
    assign in_maddr = in_moff[MEM_AW-1:0];

    // ---------------------------------------------------------------
    // Operand stage: item fields, registered reads, forwarding info
    // ---------------------------------------------------------------
    logic              r_a_vld;
    t_item_kind        r_a_op;
    logic [7:0]        r_a_opc;
    logic [7:0]        r_a_a;
    logic [7:0]        r_a_b;
    logic [RIDX_W-1:0] r_a_ia;
    logic [RIDX_W-1:0] r_a_ib;
    logic [7:0]        r_a_pidx;
    logic [7:0]        r_a_pdat;
    logic [7:0]        r_rda;
    logic [7:0]        r_rdb;
    logic [7:0]        r_rdm;
    logic              r_rda_v;
    logic              r_rdb_v;
    logic              r_rdm_v;
    logic              r_fwa_hit;
    logic              r_fwb_hit;
    logic              r_fwm_hit;
    logic [7:0]        r_fw_reg_d;
    logic [7:0]        r_fw_mem_d;

    // output register
    logic              r_o_vld;
    logic [15:0]       r_o_pc;
    t_print_kind       r_o_kind;
    logic [7:0]        r_o_pval;
    logic              r_o_halt;
    logic              r_o_ill;

    // the operand stage moves on when the output register is free or draining
    assign a_adv           = r_a_vld && (!r_o_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_a_vld || a_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_acc) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_op     <= t_item_kind'(i_s_axis_tuser[0]);
            r_a_opc    <= in_opc;
            r_a_a      <= in_a_eff;
            r_a_b      <= in_b_eff;
            r_a_ia     <= in_ia;
            r_a_ib     <= in_ib;
            r_a_pidx   <= i_s_axis_tdata[31:24];
            r_a_pdat   <= i_s_axis_tdata[39:32];
            r_rda_v    <= r_reg_vld[in_ia];
            r_rdb_v    <= r_reg_vld[in_ib];
            r_rdm_v    <= in_m_inr && r_mem_vld[in_maddr];
            // a write landing this cycle overrides the stale read
            r_fwa_hit  <= reg_we && (reg_waddr == in_ia);
            r_fwb_hit  <= reg_we && (reg_waddr == in_ib);
            r_fwm_hit  <= mem_we && in_m_inr && (mem_waddr == in_maddr);
            r_fw_reg_d <= reg_wdata;
            r_fw_mem_d <= mem_wdata;
        end
    end

    // register file read and write
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rda <= r_reg_file[in_ia];
            r_rdb <= r_reg_file[in_ib];
        end
        if (reg_we) begin
            r_reg_file[reg_waddr] <= reg_wdata;
        end
    end

    // data memory read and write
    always_ff @(posedge i_clk) begin
        if (in_acc && in_m_inr) begin
            r_rdm <= r_data_mem[in_maddr];
        end
        if (mem_we) begin
            r_data_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
            r_mem_vld <= '0;
        end else begin
            if (reg_we) begin
                r_reg_vld[reg_waddr] <= 1'b1;
            end
            if (mem_we) begin
                r_mem_vld[mem_waddr] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Execute stage
    // ---------------------------------------------------------------
    logic [7:0]  ra_val;
    logic [7:0]  rb_val;
    logic [7:0]  mem_val;
    logic [7:0]  loc_a;
    t_exec_res   res;
    logic        exec;
    logic        run;
    logic [1:0]  len;
    logic [15:0] pc_adv;
    logic [7:0]  b_off;
    logic        b_m_inr;
    logic [15:0] n_pc;
    logic        n_skip;
    logic        n_halt;

    assign ra_val  = r_fwa_hit ? r_fw_reg_d : (r_rda_v ? r_rda : 8'h00);
    assign rb_val  = r_fwb_hit ? r_fw_reg_d : (r_rdb_v ? r_rdb : 8'h00);
    assign mem_val = r_fwm_hit ? r_fw_mem_d : (r_rdm_v ? r_rdm : 8'h00);
    // below MEM_BASE a location is a register, same index as R[a]
    assign loc_a   = (r_a_a < MEM_BASE) ? ra_val : mem_val;

    tcpu_alu u_alu (
        .i_opcode (r_a_opc),
        .i_ra     (ra_val),
        .i_rb     (rb_val),
        .i_loc_a  (loc_a),
        .o_res    (res)
    );

    assign exec    = r_a_vld && (r_a_op == ITEM_EXEC) && !r_halt;
    assign run     = exec && !r_skip;          // skipped items are not decoded
    assign len     = (r_a_opc[7:6] == LEN2_TAG) ? 2'd2 :
                     (r_a_opc[7:6] == LEN3_TAG) ? 2'd3 : 2'd1;
    assign pc_adv  = r_pc + 16'(len);
    assign b_off   = r_a_b - MEM_BASE;
    assign b_m_inr = (r_a_b >= MEM_BASE) && (b_off < MEM_DEPTH_B);

    always_comb begin
        n_pc   = r_pc;
        n_skip = r_skip;
        n_halt = r_halt;
        if (exec) begin
            n_pc = (run && res.jump) ? res.jump_pc : pc_adv;
            if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                if (res.set_skip) begin
                    n_skip = 1'b1;
                end
                if (res.set_halt) begin
                    n_halt = 1'b1;
                end
            end
        end
    end

    // write port selection
    always_comb begin
        reg_we    = 1'b0;
        reg_waddr = r_a_ia;
        reg_wdata = res.reg_wdata;
        mem_we    = 1'b0;
        mem_waddr = b_off[MEM_AW-1:0];
        mem_wdata = res.reg_wdata;
        if (a_adv) begin
            if (r_a_op == ITEM_PRELOAD) begin
                mem_we    = (r_a_pidx < MEM_DEPTH_B);
                mem_waddr = r_a_pidx[MEM_AW-1:0];
                mem_wdata = r_a_pdat;
            end else if (run) begin
                if (res.reg_we) begin
                    reg_we = 1'b1;
                end else if (res.mov) begin
                    if (r_a_b < MEM_BASE) begin
                        reg_we    = 1'b1;
                        reg_waddr = r_a_ib;
                    end else begin
                        mem_we = b_m_inr;   // out of range writes are dropped
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 16'h0000;
            r_skip <= 1'b0;
            r_halt <= 1'b0;
        end else if (a_adv) begin
            r_pc   <= n_pc;
            r_skip <= n_skip;
            r_halt <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (a_adv) begin
            r_o_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o_pc   <= n_pc;
            r_o_kind <= run ? res.print_kind : PRINT_NONE;
            r_o_pval <= run ? res.print_value : 8'h00;
            r_o_halt <= n_halt;
            r_o_ill  <= run && res.illegal;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {6'd0, r_o_ill, r_o_halt, r_o_pval, r_o_pc};
    assign o_m_axis_tuser  = r_o_kind;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic out_no_print;

    assign out_no_print = r_o_vld && (r_o_kind == PRINT_NONE);

    `TCPU_ASSERT_NEXT(a_halt_sticky, r_halt, r_halt, "halt flag dropped")
    `TCPU_ASSERT_NEXT(a_halt_pc_hold, a_adv && r_halt, r_pc == $past(r_pc), "pc moved after halt")
    `TCPU_ASSERT_NEXT(a_skip_clears, exec && r_skip && a_adv, !r_skip, "skip not consumed")
    `TCPU_ASSERT_NOW(a_print_idle, out_no_print, r_o_pval == 8'h00, "print value without print")

endmodule

[tb/tiny_cpu_execute_unit_tb.sv]
// Self-checking testbench for tiny_cpu_execute_unit: a shadow CPU model tracks
// registers, data memory, pc and the skip/halt flags and checks every result item.
// Depends on tcpu_pkg and the tiny_cpu_execute_unit RTL.
`timescale 1ns / 100ps

import tcpu_pkg::*;

localparam int REG_WORDS = 8;
localparam int MEM_WORDS = 240;

typedef struct packed {
    logic [15:0] next_pc;
    t_print_kind print_kind;
    logic [7:0]  print_value;
    logic        halted;
    logic        illegal;
} t_outcome;

// Shadow of the machine state; queues the outcome of every accepted item.
class cpu_shadow;
    logic [7:0]  regs [REG_WORDS];
    logic [7:0]  mem [MEM_WORDS];
    logic [15:0] pc;
    logic        skip_flag;
    logic        halt_flag;
    t_outcome    outcomes [$];
    int          mismatches;

    function new();
        foreach (regs[i]) regs[i] = 8'h00;
        foreach (mem[i]) mem[i] = 8'h00;
        pc = 16'h0000;
        skip_flag = 1'b0;
        halt_flag = 1'b0;
        mismatches = 0;
    endfunction

    function logic [7:0] read_loc(logic [7:0] loc);
        int idx;
        if (loc < MEM_BASE) return regs[loc % REG_WORDS];
        idx = int'(loc) - int'(MEM_BASE);
        return (idx < MEM_WORDS) ? mem[idx] : 8'h00;
    endfunction

    function void write_loc(logic [7:0] loc, logic [7:0] val);
        int idx;
        if (loc < MEM_BASE) begin
            regs[loc % REG_WORDS] = val;
            return;
        end
        idx = int'(loc) - int'(MEM_BASE);
        if (idx < MEM_WORDS) mem[idx] = val;
    endfunction

    // Runs one accepted item on the shadow state and queues its outcome.
    function void step_machine(t_item_kind kind, logic [39:0] data);
        logic [7:0] opc, opa, opb, pidx, pdat, ra, rb;
        int         ai, len;
        t_outcome   res;
        opc  = data[7:0];
        opa  = data[15:8];
        opb  = data[23:16];
        pidx = data[31:24];
        pdat = data[39:32];
        res.next_pc     = pc;
        res.print_kind  = PRINT_NONE;
        res.print_value = 8'h00;
        res.illegal     = 1'b0;
        if (kind == ITEM_PRELOAD) begin
            if (pidx < MEM_WORDS) mem[pidx] = pdat;
        end else if (!halt_flag) begin
            case (opc[7:6])
                LEN2_TAG: len = 2;
                LEN3_TAG: len = 3;
                default:  len = 1;
            endcase
            res.next_pc = pc + 16'(len);
            if (len < 3) opb = 8'h00;
            if (len < 2) opa = 8'h00;
            if (skip_flag) begin
                skip_flag = 1'b0;
            end else begin
                ai = opa % REG_WORDS;
                ra = regs[ai];
                rb = regs[opb % REG_WORDS];
                case (opc)
                    OPC_NOP:    ;
                    OPC_HALT:   halt_flag = 1'b1;
                    OPC_MOV:    write_loc(opb, read_loc(opa));
                    OPC_ADD:    regs[ai] = ra + rb;
                    OPC_SUB:    regs[ai] = ra - rb;
                    OPC_PRHEX: begin
                        res.print_kind  = PRINT_HEX;
                        res.print_value = read_loc(opa);
                    end
                    OPC_PRCHR: begin
                        res.print_kind  = PRINT_CHAR;
                        res.print_value = read_loc(opa);
                    end
                    OPC_NOT:    regs[ai] = 8'(ra == 8'h00);
                    OPC_OR:     regs[ai] = 8'(ra != 8'h00 || rb != 8'h00);
                    OPC_AND:    regs[ai] = 8'(ra != 8'h00 && rb != 8'h00);
                    OPC_XOR:    regs[ai] = ra ^ rb;
                    OPC_SHR:    regs[ai] = (rb >= 8) ? 8'h00 : ra >> rb;
                    OPC_SHL:    regs[ai] = (rb >= 8) ? 8'h00 : 8'(ra << rb);
                    OPC_JMP:    res.next_pc = 16'(int'(ra) * 255 + int'(rb));
                    OPC_SKIPNZ: if (ra != 8'h00) skip_flag = 1'b1;
                    OPC_EQ:     regs[ai] = 8'(ra == rb);
                    default:    res.illegal = 1'b1;
                endcase
            end
            pc = res.next_pc;
        end
        res.halted = halt_flag;
        outcomes.insert(outcomes.size(), res);
    endfunction

    function void compare_outcome(t_outcome got);
        t_outcome want;
        if (outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result: pc=%h kind=%0d val=%h halt=%b ill=%b",
                         got.next_pc, got.print_kind, got.print_value, got.halted,
                         got.illegal);
            return;
        end
        want = outcomes.pop_front();
        if (got.next_pc !== want.next_pc || got.print_kind !== want.print_kind ||
            got.print_value !== want.print_value || got.halted !== want.halted ||
            got.illegal !== want.illegal) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("ERROR: exp pc=%h kind=%0d val=%h halt=%b ill=%b, ",
                       want.next_pc, want.print_kind, want.print_value, want.halted,
                       want.illegal);
                $display("got pc=%h kind=%0d val=%h halt=%b ill=%b",
                         got.next_pc, got.print_kind, got.print_value,
                         got.halted, got.illegal);
            end
        end
    endfunction

    function int outstanding();
        return outcomes.size();
    endfunction
endclass

module tiny_cpu_execute_unit_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    cpu_shadow shadow = new();

    int src_idle_pct = 0;   // chance per cycle that the sender idles
    int dst_stall_pct = 0;  // chance per cycle that the receiver stalls
    int hold_req = 0;       // long receiver hold-off, picked up by the receiver process
    int hold_left = 0;

    logic [7:0] legal_ops [15] = '{OPC_NOP, OPC_MOV, OPC_ADD, OPC_SUB, OPC_PRHEX,
                                   OPC_PRCHR, OPC_NOT, OPC_OR, OPC_AND, OPC_XOR,
                                   OPC_SHR, OPC_SHL, OPC_JMP, OPC_SKIPNZ, OPC_EQ};

    tiny_cpu_execute_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // opcode, operand_a, operand_b, preload_index, preload_data
        .i_s_axis_tuser  (s_tuser),   // op
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata), // next_pc, print_value, halted, illegal
        .o_m_axis_tuser  (o_m_axis_tuser)  // print_kind
    );

    always #6 i_clk = ~i_clk;

    // Receiver: random stalls, plus long hold-offs counted here so the
    // sender keeps pushing while the block backs up.
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Both handshakes sampled at the edge; values seen here are pre-edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready)
                shadow.step_machine(t_item_kind'(s_tuser[0]), s_tdata);
            if (o_m_axis_tvalid && m_tready)
                shadow.compare_outcome('{next_pc:     o_m_axis_tdata[15:0],
                                         print_kind:  t_print_kind'(o_m_axis_tuser),
                                         print_value: o_m_axis_tdata[23:16],
                                         halted:      o_m_axis_tdata[24],
                                         illegal:     o_m_axis_tdata[25]});
        end
    end

    // Offers one item, with random idle cycles ahead of it, and returns at
    // the edge where it is taken. tvalid stays high into the next item.
    task automatic send_item(t_item_kind kind, logic [39:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Unused fields carry random bits; the block must ignore them.
    task automatic send_exec(logic [7:0] opc, logic [7:0] opa, logic [7:0] opb);
        send_item(ITEM_EXEC, {8'($urandom), 8'($urandom), opb, opa, opc});
    endtask

    task automatic send_preload(logic [7:0] idx, logic [7:0] val);
        send_item(ITEM_PRELOAD, {val, idx, 8'($urandom), 8'($urandom), 8'($urandom)});
    endtask

    // Sender goes quiet until every pending result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (shadow.outstanding() != 0);
    endtask

    function automatic logic [7:0] pick_loc();
        return $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    endfunction

    task automatic send_random(bit allow_halt);
        logic [7:0] opc;
        logic [7:0] idx;
        if ($urandom_range(99) < 15) begin
            // mostly in range, some past the end of data memory
            idx = ($urandom_range(99) < 85) ? 8'($urandom_range(MEM_WORDS - 1))
                                            : 8'($urandom_range(255, MEM_WORDS));
            send_preload(idx, $urandom_range(2) == 0 ? 8'($urandom_range(9))
                                                     : 8'($urandom_range(255)));
        end else begin
            opc = ($urandom_range(99) < 80) ? legal_ops[$urandom_range(14)]
                                            : 8'($urandom_range(255));
            if (!allow_halt && opc == OPC_HALT) opc = OPC_NOP;
            send_exec(opc, pick_loc(), pick_loc());
        end
    endtask

    // Jump near the top of the address space and run long instructions so
    // the pc wraps past 0xFFFF. The nop first soaks up a pending skip.
    task automatic run_pc_wrap();
        send_exec(OPC_NOP, 8'h00, 8'h00);
        send_preload(8'd5, 8'hFF);
        send_exec(OPC_MOV, MEM_BASE + 8'd5, 8'd7);
        send_exec(OPC_JMP, 8'd7, 8'd7);
        repeat (90) send_exec(OPC_XOR, 8'($urandom_range(15)), 8'($urandom_range(15)));
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count, bit long_hold);
        src_idle_pct = idle_pct;
        dst_stall_pct = stall_pct;
        run_pc_wrap();
        for (int i = 0; i < count; i++) begin
            if (i == count / 4) drain_results();
            if (long_hold && i == count / 2) hold_req = 64;
            send_random(1'b0);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: preload extremes, every operation, skip over a halt,
        // illegal opcodes of both short lengths, wrapping arithmetic.
        send_preload(8'd0, 8'hFF);
        send_preload(8'd239, 8'h80);
        send_preload(8'd240, 8'h55);           // past the end, ignored
        send_preload(8'd255, 8'hAA);           // past the end, ignored
        send_exec(OPC_NOP, 8'hFF, 8'hFF);
        send_exec(OPC_MOV, 8'h10, 8'h01);      // R1 = mem[0]
        send_exec(OPC_MOV, 8'hFF, 8'h0A);      // index 0x0A lands on R2
        send_exec(OPC_ADD, 8'd1, 8'd2);        // wraps
        send_exec(OPC_SUB, 8'd3, 8'd1);        // wraps below zero
        send_exec(OPC_PRHEX, 8'h09, 8'h00);
        send_exec(OPC_PRCHR, 8'h10, 8'h00);
        send_exec(OPC_NOT, 8'd4, 8'h00);
        send_exec(OPC_OR, 8'd4, 8'd5);
        send_exec(OPC_AND, 8'd4, 8'd5);
        send_exec(OPC_XOR, 8'd2, 8'd1);
        send_exec(OPC_SHL, 8'd1, 8'd3);        // count of 0x81: result 0
        send_exec(OPC_SHR, 8'd3, 8'd4);
        send_exec(OPC_EQ, 8'd6, 8'd7);         // R6 = 1
        send_exec(OPC_SKIPNZ, 8'd6, 8'h00);
        send_exec(OPC_HALT, 8'h00, 8'h00);     // skipped, machine keeps running
        send_exec(8'hFF, 8'h12, 8'h34);        // illegal, one byte
        send_exec(8'h7F, 8'h12, 8'h34);        // illegal, two bytes
        send_exec(OPC_JMP, 8'd3, 8'd6);
        send_exec(OPC_MOV, 8'd2, 8'h20);
        send_exec(OPC_PRHEX, 8'h20, 8'h00);

        run_phase(0, 0, 280, 1'b1);
        run_phase(85, 0, 280, 1'b0);
        run_phase(0, 85, 280, 1'b0);
        run_phase(26, 26, 280, 1'b0);

        // Halt last: after it only preloads change anything.
        send_exec(OPC_NOP, 8'h00, 8'h00);
        send_exec(OPC_HALT, 8'h00, 8'h00);
        repeat (14) send_random(1'b1);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
            $display("tiny_cpu_execute_unit: match");
        end else begin
            $display("tiny_cpu_execute_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tiny_cpu_execute_unit: mismatch");
        $finish;
    end

endmodule
